FILE: rtl/wree_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wree_pkg
// Shared types and constants for the windowed rate EWMA estimator.
// ----------------------------------------------------------------------------
package wree_pkg;

  // field widths
  localparam int unsigned TimeW  = 32;
  localparam int unsigned BytesW = 16;
  localparam int unsigned CountW = 32;
  localparam int unsigned RateW  = 48;
  localparam int unsigned LenW   = 10;
  localparam int unsigned WgtW   = 17;
  localparam int unsigned FracW  = 16;

  // sequencer step counts
  localparam logic [5:0] DIV_NOW_STEPS  = 6'd32;
  localparam logic [5:0] DIV_RATE_STEPS = 6'd48;
  localparam logic [5:0] MUL_STEPS      = 6'd17;

  // reset values
  localparam logic [LenW-1:0]  RESET_SLICE_LEN = 10'd10;
  localparam logic [WgtW-1:0]  RESET_WEIGHT    = 17'd19661;
  localparam logic [RateW-1:0] RESET_RATE      = 48'd327680;
  localparam logic [WgtW-1:0]  ONE_Q16         = 17'd65536;

  // configuration register indexes
  localparam logic REG_SLICE_LEN = 1'b0;
  localparam logic REG_WEIGHT    = 1'b1;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_NOW,
    ST_DECIDE,
    ST_DIV_RATE,
    ST_MUL_SETUP,
    ST_MUL,
    ST_UPDATE,
    ST_FINISH
  } wree_state_t;

endpackage : wree_pkg
`default_nettype wire

FILE: rtl/windowed_rate_ewma_estimator.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// windowed_rate_ewma_estimator
// Per-packet receive rate estimator: slice byte counting, sample rate by
// bit-serial division, EWMA smoothing in unsigned Q32.16 by shift-add.
// ----------------------------------------------------------------------------
// One request is handled at a time. Its result is loaded in the result load
// step, and the block is ready again in that same cycle; a new request is
// taken only after the last one is through. The time goes to 32 steps of the
// bit-serial divider for the slice number, 48 steps of the same divider for
// the sample rate, 17 steps of the shift-add multiplier for the smoothing
// blend, and four further steps (slice decision, multiplier setup, rate
// update, result load). A request whose slice lies before the current one
// skips the rate divide, multiplier and update. The result sits in an output
// register, so a new request is accepted while it waits; a held result stalls
// the next request only at its result load. Configuration writes are taken
// only while idle, and a write in the same cycle as a request goes first.
module windowed_rate_ewma_estimator
  import wree_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  // configuration writes
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic              cfg_index,
  input  wire logic [WgtW-1:0]   cfg_data,
  // packet requests
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [TimeW-1:0]  arrival_time_ms,
  input  wire logic [BytesW-1:0] payload_bytes,
  // acknowledgments
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [31:0]            ack_sequence,
  output logic [RateW-1:0]       rate_estimate,
  output logic                   time_backwards
);

  // configuration and estimator state
  logic [LenW-1:0]   slice_length_ms;
  logic [WgtW-1:0]   smoothing_weight;
  logic [CountW-1:0] slice_index;
  logic [CountW-1:0] slice_byte_count;
  logic [RateW-1:0]  smoothed_rate;
  logic [31:0]       ack_counter;

  // sequencer
  wree_state_t state, state_next;
  logic [5:0]  step;

  // per-request holding registers
  logic [BytesW-1:0] bytes_hold;
  logic [RateW-1:0]  res_rate;
  logic              res_tb;

  // divider registers
  logic [RateW-1:0] dvd;
  logic [LenW-1:0]  rem;
  logic [LenW-1:0]  dvs;

  // multiplier registers
  logic signed [RateW:0] diff_d;
  logic [WgtW-1:0]       mult_v;
  logic [65:0]           acc;

  // effective configuration
  logic [LenW-1:0] len_eff;
  logic [WgtW-1:0] w_eff;
  assign len_eff = (slice_length_ms == '0) ? LenW'(1) : slice_length_ms;
  assign w_eff   = (smoothing_weight > ONE_Q16) ? ONE_Q16 : smoothing_weight;

  // shared restoring divide step
  logic [LenW:0]   partial;
  logic [LenW+1:0] trial;
  logic            q_bit;
  logic [LenW-1:0] rem_step;
  assign partial  = {rem, dvd[RateW-1]};
  assign trial    = {1'b0, partial} - {2'b00, dvs};
  assign q_bit    = ~trial[LenW+1];
  assign rem_step = q_bit ? trial[LenW-1:0] : partial[LenW-1:0];

  // slice decision on the first quotient
  logic [CountW-1:0] now_slice;
  logic              is_backwards;
  logic              is_same;
  logic [CountW:0]   cnt_sum;
  logic [CountW-1:0] cnt_sat;
  logic [LenW-1:0]   elapsed;
  assign now_slice    = dvd[CountW-1:0];
  assign is_backwards = now_slice < slice_index;
  assign is_same      = now_slice == slice_index;
  assign cnt_sum      = {1'b0, slice_byte_count} + (CountW + 1)'(bytes_hold);
  assign cnt_sat      = cnt_sum[CountW] ? '1 : cnt_sum[CountW-1:0];
  assign elapsed      = (rem == '0) ? LenW'(1) : rem;

  // shift-add multiply step, multiplier bits msb first
  logic [65:0] addend;
  logic [65:0] acc_step;
  assign addend   = mult_v[WgtW-1] ? {{17{diff_d[RateW]}}, diff_d} : '0;
  assign acc_step = {acc[64:0], 1'b0} + addend;

  // blended rate: old + (1 - w) * (sample - old)
  logic [RateW+1:0] rate_sum;
  assign rate_sum = {2'b00, smoothed_rate} + acc[65:16];

  // configuration only while no request is in flight
  assign cfg_ready = (state == ST_IDLE);

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and handshake
  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        // a configuration write in the same cycle goes first
        in_ready = !cfg_valid;
        if (in_valid && !cfg_valid) state_next = ST_DIV_NOW;
      end
      ST_DIV_NOW: begin
        if (step == '0) state_next = ST_DECIDE;
      end
      ST_DECIDE: begin
        state_next = is_backwards ? ST_FINISH : ST_DIV_RATE;
      end
      ST_DIV_RATE: begin
        if (step == '0) state_next = ST_MUL_SETUP;
      end
      ST_MUL_SETUP: begin
        state_next = ST_MUL;
      end
      ST_MUL: begin
        if (step == '0) state_next = ST_UPDATE;
      end
      ST_UPDATE: begin
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (!out_valid || out_ready) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // datapath and state updates
  always_ff @(posedge clk) begin
    if (rst) begin
      slice_length_ms  <= RESET_SLICE_LEN;
      smoothing_weight <= RESET_WEIGHT;
      slice_index      <= '0;
      slice_byte_count <= '0;
      smoothed_rate    <= RESET_RATE;
      ack_counter      <= '0;
      out_valid        <= 1'b0;
      step             <= '0;
    end else begin
      // register writes
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_SLICE_LEN: slice_length_ms  <= cfg_data[LenW-1:0];
          REG_WEIGHT:    smoothing_weight <= cfg_data;
          default: ;
        endcase
      end

      // result register handshake
      if (state == ST_FINISH && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (in_valid && in_ready) begin
            bytes_hold <= payload_bytes;
            dvd        <= {arrival_time_ms, {FracW{1'b0}}};
            rem        <= '0;
            dvs        <= len_eff;
            step       <= DIV_NOW_STEPS - 6'd1;
          end
        end
        ST_DIV_NOW, ST_DIV_RATE: begin
          dvd  <= {dvd[RateW-2:0], q_bit};
          rem  <= rem_step;
          step <= step - 6'd1;
        end
        ST_DECIDE: begin
          rem  <= '0;
          step <= DIV_RATE_STEPS - 6'd1;
          if (is_backwards) begin
            res_rate <= smoothed_rate;
            res_tb   <= 1'b1;
          end else if (is_same) begin
            res_tb           <= 1'b0;
            slice_byte_count <= cnt_sat;
            dvd              <= {cnt_sat, {FracW{1'b0}}};
            dvs              <= elapsed;
          end else begin
            res_tb           <= 1'b0;
            slice_index      <= now_slice;
            slice_byte_count <= CountW'(bytes_hold);
            dvd              <= {slice_byte_count, {FracW{1'b0}}};
            dvs              <= len_eff;
          end
        end
        ST_MUL_SETUP: begin
          diff_d <= $signed({1'b0, dvd}) - $signed({1'b0, smoothed_rate});
          mult_v <= ONE_Q16 - w_eff;
          acc    <= '0;
          step   <= MUL_STEPS - 6'd1;
        end
        ST_MUL: begin
          acc    <= acc_step;
          mult_v <= {mult_v[WgtW-2:0], 1'b0};
          step   <= step - 6'd1;
        end
        ST_UPDATE: begin
          smoothed_rate <= rate_sum[RateW-1:0];
          res_rate      <= rate_sum[RateW-1:0];
        end
        ST_FINISH: begin
          if (!out_valid || out_ready) begin
            ack_sequence   <= ack_counter;
            rate_estimate  <= res_rate;
            time_backwards <= res_tb;
            if (!res_tb) ack_counter <= ack_counter + 32'd1;
          end
        end
        default: ;
      endcase
    end
  end

endmodule : windowed_rate_ewma_estimator
`default_nettype wire

FILE: test/windowed_rate_ewma_estimator_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// windowed_rate_ewma_estimator_test
// Drives timestamped packets into the rate estimator under several slice
// lengths and smoothing weights. Each acknowledgment is predicted from a
// cycle-free model of the slice counter and the Q32.16 blend, then compared
// field by field in order. Both handshakes see random gaps and stalls.
// ----------------------------------------------------------------------------
module windowed_rate_ewma_estimator_test;
  import wree_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 3_000_000;
  localparam int unsigned PHASE_ITEMS  = 220;
  localparam int unsigned TAIL_CYCLES  = 200;

  // one expected acknowledgment
  typedef struct packed {
    logic [31:0]      seq;
    logic [RateW-1:0] rate;
    logic             back;
  } ack_t;

  // slice counter, blend and ack numbering, plus the in-order compare
  class rate_ack_tracker;
    bit [LenW-1:0]  slice_len;
    bit [WgtW-1:0]  weight;
    bit [31:0]      slice_idx;
    bit [31:0]      byte_count;
    bit [RateW-1:0] rate;
    bit [31:0]      ack_count;
    ack_t           acks_due[$];
    int unsigned    mismatches;
    int unsigned    checked;
    int unsigned    in_slice;
    int unsigned    new_slice;
    int unsigned    backward;

    function new();
      slice_len  = RESET_SLICE_LEN;
      weight     = RESET_WEIGHT;
      slice_idx  = '0;
      byte_count = '0;
      rate       = RESET_RATE;
      ack_count  = '0;
    endfunction

    function void set_config(logic idx, bit [WgtW-1:0] data);
      if (idx == REG_SLICE_LEN) begin
        slice_len = data[LenW-1:0];
      end else begin
        weight = data;
      end
    endfunction

    // work out the acknowledgment that an accepted packet causes
    function void note_packet(bit [31:0] t, bit [15:0] nbytes);
      bit [63:0] len;
      bit [63:0] w;
      bit [63:0] now;
      bit [63:0] elapsed;
      bit [63:0] cnt;
      bit [63:0] sample;
      bit [81:0] blend;
      ack_t      exp;
      len = (slice_len == 0) ? 64'd1 : 64'(slice_len);
      w = (weight > ONE_Q16) ? 64'(ONE_Q16) : 64'(weight);
      now = t / len;
      exp.seq = ack_count;
      if (now < slice_idx) begin
        // slice already closed: state frozen, flag raised
        exp.rate = rate;
        exp.back = 1'b1;
        backward++;
      end else begin
        if (now == slice_idx) begin
          elapsed = t - slice_idx * len;
          if (elapsed == 0) elapsed = 1;
          cnt = byte_count + nbytes;
          if (cnt > 64'hFFFF_FFFF) cnt = 64'hFFFF_FFFF;
          byte_count = cnt[31:0];
          sample = (cnt << 16) / elapsed;
          in_slice++;
        end else begin
          sample = (64'(byte_count) << 16) / len;
          slice_idx = now[31:0];
          byte_count = 32'(nbytes);
          new_slice++;
        end
        blend = w * rate + (64'(ONE_Q16) - w) * sample;
        rate = blend[FracW +: RateW];
        exp.rate = rate;
        exp.back = 1'b0;
        ack_count = ack_count + 1;
      end
      acks_due.push_back(exp);
    endfunction

    function void check_ack(bit [31:0] seq, bit [RateW-1:0] r, bit back);
      ack_t exp;
      checked++;
      if (acks_due.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected ack seq %0d rate 0x%h back %0b", seq, r, back);
        mismatches++;
      end else begin
        exp = acks_due.pop_front();
        if (exp.seq != seq || exp.rate != r || exp.back != back) begin
          if (mismatches < 10)
            $display("ack mismatch: expected seq %0d rate 0x%h back %0b, got seq %0d rate 0x%h back %0b",
                     exp.seq, exp.rate, exp.back, seq, r, back);
          mismatches++;
        end
      end
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic              cfg_index = REG_SLICE_LEN;
  logic [WgtW-1:0]   cfg_data = '0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [TimeW-1:0]  arrival_time_ms = '0;
  logic [BytesW-1:0] payload_bytes = '0;
  logic              out_valid;
  logic              out_ready = 1'b1;
  logic [31:0]       ack_sequence;
  logic [RateW-1:0]  rate_estimate;
  logic              time_backwards;

  rate_ack_tracker acks;
  bit              tx_gaps = 1'b1;
  bit              rx_stalls = 1'b1;
  bit [63:0]       cur_time = '0;
  int unsigned     cycle_count = 0;
  int unsigned     phases_run = 0;

  windowed_rate_ewma_estimator u_top (
    .clk             (clk),
    .rst             (rst),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .arrival_time_ms (arrival_time_ms),
    .payload_bytes   (payload_bytes),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .ack_sequence    (ack_sequence),
    .rate_estimate   (rate_estimate),
    .time_backwards  (time_backwards)
  );

  // 100 MHz clock
  initial begin
    forever #5 clk = ~clk;
  end

  // mostly short idles, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 4);
    return $urandom_range(20, 150);
  endfunction

  // acknowledgment side back-pressure
  initial begin : ready_gen
    int unsigned hold;
    forever begin
      @(posedge clk);
      if (rx_stalls && $urandom_range(0, 3) == 0) begin
        hold = pick_gap() + 1;
        out_ready <= 1'b0;
        repeat (hold) @(posedge clk);
        out_ready <= 1'b1;
      end
    end
  end

  // compare every accepted acknowledgment
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      acks.check_ack(ack_sequence, rate_estimate, time_backwards);
  end

  // run watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d acks pending", cycle_count,
               acks.acks_due.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  // present one packet request and hold it until taken
  task automatic send_packet(input bit [31:0] t, input bit [15:0] nbytes);
    int unsigned idle;
    in_valid <= 1'b1;
    arrival_time_ms <= t;
    payload_bytes <= nbytes;
    do @(posedge clk); while (!in_ready);
    acks.note_packet(t, nbytes);
    idle = tx_gaps ? pick_gap() : 0;
    if (idle != 0) begin
      in_valid <= 1'b0;
      repeat (idle) @(posedge clk);
    end
  endtask

  task automatic in_idle();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drain();
    while (acks.acks_due.size() != 0) @(posedge clk);
  endtask

  // write slice length then weight, back to back
  task automatic write_config(input bit [WgtW-1:0] len_word, input bit [WgtW-1:0] wgt_word);
    cfg_valid <= 1'b1;
    cfg_index <= REG_SLICE_LEN;
    cfg_data <= len_word;
    do @(posedge clk); while (!cfg_ready);
    acks.set_config(REG_SLICE_LEN, len_word);
    cfg_index <= REG_WEIGHT;
    cfg_data <= wgt_word;
    do @(posedge clk); while (!cfg_ready);
    acks.set_config(REG_WEIGHT, wgt_word);
    cfg_valid <= 1'b0;
  endtask

  // mostly forward-moving time with random content, some stale packets
  task automatic run_phase(input int unsigned n_items);
    bit [63:0]   len;
    bit [63:0]   now;
    bit [63:0]   t;
    bit [63:0]   base;
    int unsigned roll;
    bit [15:0]   nbytes;
    len = (acks.slice_len == 0) ? 64'd1 : 64'(acks.slice_len);
    base = (64'(acks.slice_idx) + 1) * len;
    if (cur_time < base) cur_time = base;
    for (int unsigned k = 0; k < n_items; k++) begin
      // hold off once per phase until the pipe is empty
      if (k == n_items / 2) begin
        in_idle();
        wait_drain();
      end
      roll = $urandom_range(0, 99);
      now = cur_time / len;
      if (roll < 6 && cur_time != 0) begin
        t = $urandom_range(0, 32'(cur_time - 1));
      end else begin
        if (roll < 55)
          t = cur_time + $urandom_range(0, 32'(len / 3));
        else if (roll < 82)
          t = (now + 1) * len + $urandom_range(0, 32'(len - 1));
        else if (roll < 97)
          t = cur_time + $urandom_range(32'(len), 32'(8 * len));
        else
          t = cur_time + $urandom_range(0, 1 << 20);
        if (t > 64'hFFFF_FFFF) t = 64'hFFFF_FFFF;
        cur_time = t;
      end
      roll = $urandom_range(0, 9);
      nbytes = (roll == 0) ? 16'd0 : (roll == 1) ? 16'hFFFF : 16'($urandom);
      send_packet(t[31:0], nbytes);
    end
  endtask

  initial begin : stimulus
    bit [31:0]       dir_time [11];
    bit [15:0]       dir_bytes [11];
    bit [31:0]       tail_time [6];
    bit [15:0]       tail_bytes [6];
    bit [LenW-1:0]   len_val;
    bit [WgtW-1:0]   wgt_val;
    int unsigned     leftover;
    dir_time  = '{0, 0, 3, 9, 10, 2, 15, 35, 35, 29, 39};
    dir_bytes = '{0, 16'hFFFF, 16'hFFFF, 1, 100, 7, 0, 16'hFFFF, 16'hFFFF, 1, 12345};
    tail_time  = '{32'h5555_5555, 32'hAAAA_AAAA, 32'hFFFF_FFFE, 32'hFFFF_FFFF,
                   32'hFFFF_FFFF, 32'h0000_0000};
    tail_bytes = '{16'h5555, 16'hAAAA, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000};
    acks = new();
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // reset settings: zero elapsed time, slice roll-over, skipped slices,
    // stale packets
    foreach (dir_time[i]) send_packet(dir_time[i], dir_bytes[i]);
    in_idle();
    wait_drain();

    // sweep the settings, extremes included
    for (int p = 0; p < 6; p++) begin
      case (p)
        0: begin len_val = 10'd1023; wgt_val = 17'd0; end
        1: begin len_val = 10'd1023; wgt_val = ONE_Q16; end
        2: begin len_val = 10'($urandom_range(2, 1022)); wgt_val = 17'($urandom); end
        3: begin len_val = 10'd10; wgt_val = 17'h1FFFF; end
        4: begin len_val = 10'd1; wgt_val = 17'd65535; end
        default: begin len_val = 10'd0; wgt_val = 17'($urandom_range(0, 65536)); end
      endcase
      tx_gaps = (p != 2 && p != 4);
      rx_stalls = (p != 1 && p != 4);
      // upper bits of a slice length write are don't-care
      write_config({7'($urandom), len_val}, wgt_val);
      run_phase(PHASE_ITEMS);
      // top of the time range, then one stale packet at time zero
      if (p == 5) begin
        foreach (tail_time[i]) send_packet(tail_time[i], tail_bytes[i]);
      end
      in_idle();
      wait_drain();
      phases_run++;
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    leftover = acks.acks_due.size();
    $display("covered %0d packets over %0d settings plus reset defaults", acks.checked,
             phases_run);
    $display("  %0d in-slice, %0d slice openings, %0d stale, %0d mismatches",
             acks.in_slice, acks.new_slice, acks.backward, acks.mismatches);
    if (acks.mismatches == 0 && leftover == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
